/* hw/rtl/idw_pkg.sv */
`timescale 1ns / 1ps
package idw_pkg;

  localparam int CoordW = 10;
  localparam int ValW   = 16;
  localparam int CfgW   = 16;
  localparam int SqW    = 21;  // dx^2 + dy^2
  localparam int DistW  = 19;  // sqrt with 8 fraction bits
  localparam int DenW   = 57;  // d^3
  localparam int WgtW   = 33;  // weight <= 2^32
  localparam int ProdW  = WgtW + ValW;
  localparam int WsumW  = 64;
  localparam int WtW    = 41;
  localparam int CntW   = 7;

  localparam logic REG_INV_POWER = 1'b0;
  localparam logic REG_NODATA    = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] station_x;
    logic [CoordW-1:0] station_y;
    logic [ValW-1:0]   station_value;
    logic              has_series;
    logic              last_station;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] interpolated_value;
    logic            result_valid;
    logic            on_station;
  } out_item_t;

endpackage

/* hw/rtl/idw_if.sv */
`timescale 1ns / 1ps
interface idw_in_if import idw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface idw_out_if import idw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/inverse_distance_weighting_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Handshake
// in_ch     in   cell/station position, value, flags       valid/ready
// out_ch    out  interpolated_value, result_valid, on_st.  valid/ready
// cfg       in   cfg_index, cfg_data                       cfg_we, no wait
//
// A skipped item is taken in S_IDLE; others run square root, shift-add
// power if p > 1, weight divide, multiply and accumulate. A last station
// adds S_FIN and, unless coincidence or a zero weight sum decides, the
// restoring 64/41 mean divide. Synchronous reset clears the sequencer,
// sums and output valid. in_ch is held off while an item is worked; a
// result waiting on out_ch stalls only the next last station item.
module inverse_distance_weighting_unit import idw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  idw_in_if.sink            in_ch,
  idw_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQRT = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MULV = 9'b000010000,
    S_ACC  = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_FDIV = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;

  logic [1:0]       inv_power;
  logic [ValW-1:0]  nodata;
  logic [WsumW-1:0] weighted_sum;
  logic [WtW-1:0]   weight_sum;
  logic             coin_flag;
  logic [ValW-1:0]  coin_value;

  logic [ValW-1:0]  val;
  logic             last;
  logic [1:0]       passes;
  logic [CntW-1:0]  cnt;

  logic [2*DistW-1:0] sq_v;
  logic [DistW+1:0]   sq_rem;
  logic [DistW-1:0]   root;
  logic [DistW-1:0]   dist_fx;
  logic [DenW-1:0]    mcand;
  logic [DenW-1:0]    macc;
  logic [DistW-1:0]   mplier;
  logic [DenW-1:0]    den;
  logic [DenW-1:0]    drem;
  logic [WgtW-1:0]    wq;
  logic [ProdW-1:0]   prod;
  logic [WsumW-1:0]   dvd;
  logic [WtW-1:0]     frem;
  logic [ValW-1:0]    fq;
  logic               fovf;

  // input side
  logic [CoordW-1:0] dx, dy;
  logic [SqW-1:0]    sq;
  logic [1:0]        p_eff;
  in_item_t          it;

  assign it    = in_ch.payload;
  assign dx    = (it.cell_x >= it.station_x) ? it.cell_x - it.station_x
                                             : it.station_x - it.cell_x;
  assign dy    = (it.cell_y >= it.station_y) ? it.cell_y - it.station_y
                                             : it.station_y - it.cell_y;
  assign sq    = SqW'(dx * dx) + SqW'(dy * dy);
  assign p_eff = (inv_power == 2'd0) ? 2'd1 : inv_power;

  assign in_ch.ready = (state == S_IDLE);
  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  // square root step, two radicand bits a cycle
  logic [DistW+1:0] sq_rs;
  logic [DistW+1:0] sq_trial;
  logic             sq_ge;
  assign sq_rs    = {sq_rem[DistW-1:0], sq_v[2*DistW-1 -: 2]};
  assign sq_trial = {root, 2'b01};
  assign sq_ge    = sq_rs >= sq_trial;

  // shift-add multiply step
  logic [DenW-1:0] macc_next;
  assign macc_next = mplier[0] ? macc + mcand : macc;

  // weight divide step; dividend is the single bit 2^(32+8p)
  logic [DenW:0] d_rs;
  logic          d_ge;
  logic [CntW-1:0] num_pos;
  assign num_pos = CntW'(32) + CntW'({p_eff, 3'b000});
  assign d_rs    = {drem, (cnt == num_pos)};
  assign d_ge    = d_rs >= {1'b0, den};

  // mean divide step
  logic [WtW:0] f_rs;
  logic         f_ge;
  assign f_rs = {frem, dvd[WsumW-1]};
  assign f_ge = f_rs >= {1'b0, weight_sum};

  // saturating accumulate
  logic [WsumW:0] ws_add;
  logic [WtW:0]   wt_add;
  assign ws_add = {1'b0, weighted_sum} + (WsumW+1)'(prod);
  assign wt_add = {1'b0, weight_sum} + (WtW+1)'(wq);

  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;

  logic out_load;
  assign out_load = (state == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_power <= 2'd1;
      nodata    <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_POWER: inv_power <= cfg_data[1:0];
        REG_NODATA:    nodata    <= cfg_data[ValW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      weighted_sum <= '0;
      weight_sum   <= '0;
      coin_flag    <= 1'b0;
      coin_value   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            val  <= it.station_value;
            last <= it.last_station;
            if (it.has_series && sq == '0) begin
              coin_flag  <= 1'b1;
              coin_value <= it.station_value;
            end
            if (it.has_series && sq != '0 && it.station_value != nodata) begin
              sq_v   <= {1'b0, sq, 16'b0};
              sq_rem <= '0;
              root   <= '0;
              cnt    <= CntW'(DistW - 1);
              state  <= S_SQRT;
            end else if (it.last_station) begin
              state <= S_FIN;
            end
          end
        end
        S_SQRT: begin
          sq_v   <= {sq_v[2*DistW-3:0], 2'b00};
          sq_rem <= sq_ge ? sq_rs - sq_trial : sq_rs;
          root   <= {root[DistW-2:0], sq_ge};
          if (cnt == '0) begin
            dist_fx <= {root[DistW-2:0], sq_ge};
            drem    <= '0;
            if (p_eff == 2'd1) begin
              den   <= DenW'({root[DistW-2:0], sq_ge});
              cnt   <= CntW'(DenW - 1);
              state <= S_DIV;
            end else begin
              mcand  <= DenW'({root[DistW-2:0], sq_ge});
              mplier <= {root[DistW-2:0], sq_ge};
              macc   <= '0;
              passes <= p_eff - 2'd1;
              cnt    <= CntW'(DistW - 1);
              state  <= S_MUL;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            if (passes == 2'd1) begin
              den   <= macc_next;
              drem  <= '0;
              cnt   <= CntW'(DenW - 1);
              state <= S_DIV;
            end else begin
              mcand  <= macc_next;
              mplier <= dist_fx;
              macc   <= '0;
              passes <= passes - 2'd1;
              cnt    <= CntW'(DistW - 1);
            end
          end else begin
            macc   <= macc_next;
            mcand  <= {mcand[DenW-2:0], 1'b0};
            mplier <= {1'b0, mplier[DistW-1:1]};
            cnt    <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          drem <= d_ge ? DenW'(d_rs - {1'b0, den}) : DenW'(d_rs);
          wq   <= {wq[WgtW-2:0], d_ge};
          if (cnt == '0) state <= S_MULV;
          else cnt <= cnt - 1'b1;
        end
        S_MULV: begin
          prod  <= wq * val;
          state <= S_ACC;
        end
        S_ACC: begin
          weighted_sum <= ws_add[WsumW] ? '1 : ws_add[WsumW-1:0];
          weight_sum   <= wt_add[WtW] ? '1 : wt_add[WtW-1:0];
          state        <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          dvd   <= weighted_sum;
          frem  <= '0;
          fq    <= '0;
          fovf  <= 1'b0;
          cnt   <= CntW'(WsumW - 1);
          state <= (coin_flag || weight_sum == '0) ? S_OUT : S_FDIV;
        end
        S_FDIV: begin
          dvd  <= {dvd[WsumW-2:0], 1'b0};
          frem <= f_ge ? WtW'(f_rs - {1'b0, weight_sum}) : WtW'(f_rs);
          fq   <= {fq[ValW-2:0], f_ge};
          fovf <= fovf | fq[ValW-1];
          if (cnt == '0) state <= S_OUT;
          else cnt <= cnt - 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            if (coin_flag) begin
              out_ch.payload <= '{interpolated_value: coin_value,
                                  result_valid: 1'b1, on_station: 1'b1};
            end else if (weight_sum == '0) begin
              out_ch.payload <= '{interpolated_value: '0,
                                  result_valid: 1'b0, on_station: 1'b0};
            end else begin
              out_ch.payload <= '{interpolated_value: fovf ? '1 : fq,
                                  result_valid: 1'b1, on_station: 1'b0};
            end
            weighted_sum <= '0;
            weight_sum   <= '0;
            coin_flag    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_ch.valid)
    else $error("result not presented");
  a_wdiv_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (drem < den))
    else $error("weight divide remainder out of range");
  a_fdiv_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_FDIV) |-> (frem < weight_sum))
    else $error("mean divide remainder out of range");
`endif

endmodule

/* tb/inverse_distance_weighting_unit_tb.sv */
`timescale 1ns / 1ps
module inverse_distance_weighting_unit_tb;
  import idw_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CfgW-1:0] cfg_data;

  idw_in_if in_ch ();
  idw_out_if out_ch ();

  inverse_distance_weighting_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow state of the block
  logic [1:0]      power_q;
  logic [ValW-1:0] nodata_q;
  logic [63:0]     wsum_q;
  logic [WtW-1:0]  wtot_q;
  logic            coinc_q;
  logic [ValW-1:0] coinc_val_q;

  out_item_t cell_results[$];
  int        err_count;
  int        idle_cycles;
  logic      in_busy;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // accumulate one station; queue the cell result on a last station
  task automatic predict_station(input in_item_t it);
    logic [63:0] dx, dy, sq, d, den, num, w, prod;
    int p;
    out_item_t r;
    if (it.has_series) begin
      dx = it.cell_x >= it.station_x ? it.cell_x - it.station_x : it.station_x - it.cell_x;
      dy = it.cell_y >= it.station_y ? it.cell_y - it.station_y : it.station_y - it.cell_y;
      sq = dx * dx + dy * dy;
      if (sq == 0) begin
        coinc_q = 1'b1;
        coinc_val_q = it.station_value;
      end else if (it.station_value != nodata_q) begin
        p = power_q == 0 ? 1 : int'(power_q);
        d = int_sqrt(sq << 16);
        den = d;
        if (p >= 2) den *= d;
        if (p >= 3) den *= d;
        num = 64'd1 << (32 + 8 * p);
        w = num / den;
        prod = w * it.station_value;
        wsum_q = (wsum_q > ~64'd0 - prod) ? ~64'd0 : wsum_q + prod;
        wtot_q = ({23'd0, wtot_q} > {23'd0, {WtW{1'b1}}} - w) ? {WtW{1'b1}}
                 : wtot_q + w[WtW-1:0];
      end
    end
    if (it.last_station) begin
      if (coinc_q) r = '{coinc_val_q, 1'b1, 1'b1};
      else if (wtot_q == 0) r = '{16'd0, 1'b0, 1'b0};
      else begin
        w = wsum_q / {23'd0, wtot_q};
        r = '{(w > 64'hFFFF) ? 16'hFFFF : w[15:0], 1'b1, 1'b0};
      end
      cell_results = {cell_results, r};
      wsum_q = 0;
      wtot_q = 0;
      coinc_q = 1'b0;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_INV_POWER) power_q = val[1:0];
    else nodata_q = val;
  endtask

  task automatic release_input;
    if (in_busy) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  task automatic gap(input int ceiling);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, ceiling)
        : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      release_input();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_station(input in_item_t it);
    gap(40);
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    in_busy = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_station(it);
  endtask

  task automatic drain_and_settle;
    release_input();
    while (cell_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // sink side: random stalls, compare on each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cell_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.payload.interpolated_value, -1);
        end else begin
          want = cell_results.pop_front();
          if (out_ch.payload.interpolated_value !== want.interpolated_value)
            report_mismatch("interpolated_value", out_ch.payload.interpolated_value,
                            want.interpolated_value);
          if (out_ch.payload.result_valid !== want.result_valid)
            report_mismatch("result_valid", out_ch.payload.result_valid,
                            want.result_valid);
          if (out_ch.payload.on_station !== want.on_station)
            report_mismatch("on_station", out_ch.payload.on_station, want.on_station);
        end
      end
      out_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("inverse_distance_weighting_unit_tb: done, errors");
      $finish;
    end
  end

  typedef struct {
    in_item_t   stim;
    logic       check;
    out_item_t  want;
  } stim_row_t;

  stim_row_t directed[13] = '{
    // no usable station after reset
    '{'{10'd5, 10'd5, 10'd9, 10'd9, 16'd100, 1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    // nodata at nonzero distance, last
    '{'{10'd0, 10'd0, 10'd1, 10'd0, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0}},
    // single station gives its own value
    '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 16'd1234, 1'b1, 1'b1}, 1'b1, '{16'd1234, 1'b1, 1'b0}},
    '{'{10'd1023, 10'd1023, 10'd0, 10'd0, 16'd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b1, 1'b0}},
    '{'{10'd1023, 10'd0, 10'd0, 10'd1023, 16'hFFFE, 1'b1, 1'b1}, 1'b1, '{16'hFFFE, 1'b1, 1'b0}},
    // coincident station wins, last one even if nodata
    '{'{10'd7, 10'd9, 10'd1, 10'd2, 16'd50, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd7, 10'd9, 10'd7, 10'd9, 16'd77, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd7, 10'd9, 10'd7, 10'd9, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    // mix of stations, skipped last
    '{'{10'd100, 10'd200, 10'd103, 10'd204, 16'd1000, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd100, 10'd200, 10'd90, 10'd200, 16'd3000, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd100, 10'd200, 10'd100, 10'd200, 16'd5, 1'b0, 1'b1}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd0, 10'd1023, 10'd1023, 10'd0, 16'd65000, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0, 1'b0}},
    '{'{10'd0, 10'd1023, 10'd1, 10'd1023, 16'd1, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0, 1'b0}}
  };

  function automatic in_item_t rand_station(input logic [9:0] cx, input logic [9:0] cy,
                                            input logic end_cell);
    in_item_t it;
    it.cell_x = cx;
    it.cell_y = cy;
    case ($urandom_range(0, 9))
      0: begin it.station_x = cx; it.station_y = cy; end
      1, 2: begin
        it.station_x = 10'(cx + $urandom_range(0, 6) - 3);
        it.station_y = 10'(cy + $urandom_range(0, 6) - 3);
      end
      default: begin it.station_x = 10'($urandom); it.station_y = 10'($urandom); end
    endcase
    it.station_value = ($urandom_range(0, 9) == 0) ? nodata_q : 16'($urandom);
    it.has_series = $urandom_range(0, 7) != 0;
    it.last_station = end_cell;
    return it;
  endfunction

  initial begin
    logic [9:0] cx, cy;
    int n_st;
    int sent;
    out_item_t r;
    err_count = 0;
    in_busy = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_INV_POWER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    power_q = 2'd1;
    nodata_q = 16'hFFFF;
    wsum_q = 0;
    wtot_q = 0;
    coinc_q = 1'b0;
    coinc_val_q = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_station(directed[i].stim);
      if (directed[i].check && directed[i].stim.last_station) begin
        r = cell_results[$];
        if (r != directed[i].want) report_mismatch("directed row", i, -1);
      end
    end
    drain_and_settle();

    // register extremes including power 0, then other settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_INV_POWER, 16'd3); write_reg(REG_NODATA, 16'd0); end
        1: begin write_reg(REG_INV_POWER, 16'd0); write_reg(REG_NODATA, 16'hFFFF); end
        2: begin write_reg(REG_INV_POWER, 16'd2); write_reg(REG_NODATA, 16'($urandom)); end
        3: begin write_reg(REG_INV_POWER, 16'd1); write_reg(REG_NODATA, 16'h5A5A); end
        default: begin write_reg(REG_INV_POWER, 16'($urandom_range(1, 3)));
                       write_reg(REG_NODATA, 16'hFFFF); end
      endcase
      sent = 0;
      while (sent < 80) begin
        cx = 10'($urandom);
        cy = 10'($urandom);
        n_st = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int k = 0; k < n_st; k++)
          send_station(rand_station(cx, cy, k == n_st - 1));
        // occasional stray item with random last flag
        if ($urandom_range(0, 7) == 0) begin
          cx = 10'($urandom);
          send_station(rand_station(cx, cy, 1'($urandom_range(0, 1))));
          sent++;
        end
        sent += n_st;
        if ($urandom_range(0, 30) == 0) begin
          release_input();
          @(posedge clk);
          while (cell_results.size() != 0) @(posedge clk);
        end
      end
      // close any open cell before touching registers
      send_station(rand_station(cx, cy, 1'b1));
      drain_and_settle();
    end

    if (err_count == 0)
      $display("inverse_distance_weighting_unit_tb: done, clean");
    else
      $display("inverse_distance_weighting_unit_tb: done, errors");
    $finish;
  end

endmodule

/* inverse_distance_weighting_unit.f */
hw/rtl/idw_pkg.sv
hw/rtl/idw_if.sv
hw/rtl/inverse_distance_weighting_unit.sv
tb/inverse_distance_weighting_unit_tb.sv
